>>> rtl/aes_pkg.sv
// shared types, constants and round functions for the aes-128 encrypt pipeline
`timescale 1ns / 1ps
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned HalfW     = 64;

  // configuration register indexes
  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow  = 1'b1;
  localparam int unsigned CfgIdxW = 8;

  typedef logic [BlockW-1:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of a block sits at bits 127-8i down
  function automatic logic [7:0] get_byte(block_t b, int unsigned i);
    return b[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // subbytes then shiftrows
  function automatic block_t sub_shift(block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[BlockW-1-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
    end
    return t;
  endfunction

  // next round key from the previous one
  function automatic block_t next_key(block_t k, logic [7:0] rc);
    block_t n;
    logic [31:0] t;
    t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    n[127:96] = k[127:96] ^ t;
    n[95:64]  = k[95:64] ^ n[127:96];
    n[63:32]  = k[63:32] ^ n[95:64];
    n[31:0]   = k[31:0] ^ n[63:32];
    return n;
  endfunction

endpackage

>>> rtl/aes128_block_encrypt_unit.sv
// aes-128 encrypt top level: one round per pipeline stage
`timescale 1ns / 1ps
// usage:
//   s_axis_* carries a plaintext item, m_axis_* the ciphertext item; tdata
//   holds the high half in bits 63:0 and the low half in bits 127:64.
//   cfg_* writes the key: index 0 is key_high, index 1 key_low, other
//   indexes are ignored. Write only while the pipeline is empty.
// pipeline: eleven stages, the initial key add stage plus ten round
//   stages, one round each.
// throughput: one item per cycle unless the output stalls; each stage's
//   round key is expanded alongside its data: no item waits on another.
// reset: all stage valid bits and both key registers clear to zero.
// stall: when m_axis_tready is low a full output stage holds and only the
//   stages behind the first empty one move up; s_axis_tready stays high
//   while any stage is empty, so bubbles are squeezed out and no item is
//   lost or repeated.
module aes128_block_encrypt_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // plaintext_low, plaintext_high
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // ciphertext_low, ciphertext_high
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  localparam int unsigned Stages = aes_pkg::NumRounds + 1;

  logic [63:0] key_high_q, key_low_q;
  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] adv;
  aes_pkg::block_t st_q [Stages];
  aes_pkg::block_t rk_q [Stages];
  aes_pkg::block_t st_d [Stages];
  aes_pkg::block_t rk_d [Stages];

  assign cfg_ready = 1'b1;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == {{(aes_pkg::CfgIdxW-1){1'b0}}, aes_pkg::CfgKeyHigh}) begin
        key_high_q <= cfg_wdata;
      end else if (cfg_index == {{(aes_pkg::CfgIdxW-1){1'b0}}, aes_pkg::CfgKeyLow}) begin
        key_low_q <= cfg_wdata;
      end
    end
  end

  // stage advance: a stage loads when it is empty or its content moves on
  always_comb begin
    adv[Stages-1] = !vld_q[Stages-1] || m_axis_tready;
    for (int i = Stages-2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign s_axis_tready = adv[0];

  // per-stage round logic
  always_comb begin
    aes_pkg::block_t k0;
    aes_pkg::block_t pt;
    k0 = {key_high_q, key_low_q};
    pt = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    st_d[0] = pt ^ k0;
    rk_d[0] = k0;
    for (int i = 1; i < Stages; i++) begin
      rk_d[i] = aes_pkg::next_key(rk_q[i-1], aes_pkg::RCON[i-1]);
      if (i == Stages-1) begin
        st_d[i] = aes_pkg::sub_shift(st_q[i-1]) ^ rk_d[i];
      end else begin
        st_d[i] = aes_pkg::mix_columns(aes_pkg::sub_shift(st_q[i-1])) ^ rk_d[i];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < Stages; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Stages; i++) begin
      if (adv[i]) begin
        st_q[i] <= st_d[i];
        rk_q[i] <= rk_d[i];
      end
    end
  end

  assign m_axis_tvalid = vld_q[Stages-1];
  assign m_axis_tdata  = {st_q[Stages-1][63:0], st_q[Stages-1][127:64]};

endmodule

>>> rtl/aes_checker.sv
// port-level checks for the aes-128 encrypt unit
`timescale 1ns / 1ps
module aes_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         cfg_ready
);

  // a held output keeps its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");

  // with the output not valid the pipeline has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a draining output frees the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // key writes are never back-pressured
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready)
    else $error("config port stalled");

endmodule

bind aes128_block_encrypt_unit aes_checker u_aes_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .cfg_ready(cfg_ready)
);
